@@ rtl/cp949_utf8_transcoder_top_macros.svh @@
// Assertion macros shared by the transcoder's checker.
// Depends on nothing; included by the checker file.
`ifndef CP949_UTF8_TRANSCODER_TOP_MACROS_SVH
`define CP949_UTF8_TRANSCODER_TOP_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define CP949_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("transcoder assertion failed");

// Next-cycle implication, switched off while reset is held.
`define CP949_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("transcoder assertion failed");

// Next-cycle implication that is checked through reset as well.
`define CP949_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("transcoder assertion failed");

`endif

@@ rtl/cp949u8_pkg.sv @@
// Package of the CP949 / UTF-8 transcoder: item types, codes and constants.
// Depends on nothing; used by the top level, the checker and the testbench.
package cp949u8_pkg;

    // Width of a table index or table value.
    localparam int IDX_W = 16;

    // Item kinds.
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_FWD_LOAD = 2'd1;
    localparam logic [1:0] KIND_REV_LOAD = 2'd2;

    // Number of stream bytes held back.
    localparam logic [1:0] PEND_EMPTY = 2'd0;
    localparam logic [1:0] PEND_ONE   = 2'd1;
    localparam logic [1:0] PEND_TWO   = 2'd2;

    // Encoding constants.
    localparam logic [15:0] EUC_BASE   = 16'h8141;
    localparam logic [7:0]  UTF8_LEAD3 = 8'he0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;

    typedef enum logic [1:0] {
        JOB_PASS,
        JOB_EUC,
        JOB_UTF
    } t_job;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_init_state;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       in_byte;
        logic [IDX_W-1:0] table_index;
        logic [IDX_W-1:0] table_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

endpackage

@@ rtl/cp949u8_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module cp949u8_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cp949_utf8_transcoder_top.sv @@
// Transcoder between CP949 (EUC-KR) and UTF-8 with two table memories.
// The first result byte of an item is shown after the lookup stage register and the
// output buffer. One output byte per cycle while the receiver is ready; an item gives
// up to three bytes (three for a Hangul lookup in EUC-to-UTF-8 mode) in the output buffer.
// Reset clears control state, then a clearing pass over REVERSE_DEPTH addresses zeroes
// both tables, during which no item is accepted.
module cp949_utf8_transcoder_top
    import cp949u8_pkg::*;
#(
    parameter int FORWARD_DEPTH = 32768,
    parameter int REVERSE_DEPTH = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data
);

    localparam int FAW = $clog2(FORWARD_DEPTH);
    localparam int RAW = $clog2(REVERSE_DEPTH);
    localparam logic [IDX_W:0] FWD_LIMIT = (IDX_W + 1)'(FORWARD_DEPTH);
    localparam logic [IDX_W:0] REV_LIMIT = (IDX_W + 1)'(REVERSE_DEPTH);
    localparam logic [RAW-1:0] CLR_LAST  = RAW'(REVERSE_DEPTH - 1);

    // Initialisation state and clearing sweep.
    t_init_state    r_state, n_state;
    logic [RAW-1:0] r_clr_addr, n_clr_addr;
    logic           clearing;

    // Stream state.
    logic       r_direction;
    logic [1:0] r_pending, n_pending;
    logic [7:0] r_first, n_first;
    logic [7:0] r_second, n_second;

    // Lookup stage.
    logic       r_s1_valid;
    t_job       r_s1_job;
    logic [7:0] r_s1_byte;
    logic [7:0] r_s1_first;
    logic [7:0] r_s1_second;
    logic       r_s1_hit;
    logic       s1_adv;

    // Output buffer, oldest byte in slot 0.
    logic [7:0] r_ob_byte [3];
    logic [1:0] r_ob_cnt;

    // Item decode.
    logic             accept;
    logic [7:0]       in_b;
    logic [15:0]      pair;
    logic [15:0]      euc_off;
    logic [15:0]      code_point;
    logic             s0_load;
    t_job             s0_job;
    logic             s0_hit;
    logic             fwd_re;
    logic             rev_re;

    // Memory ports.
    logic             fwd_we;
    logic [FAW-1:0]   fwd_waddr;
    logic [15:0]      fwd_wdata;
    logic [15:0]      fwd_rdata;
    logic             rev_we;
    logic [RAW-1:0]   rev_waddr;
    logic [15:0]      rev_wdata;
    logic [15:0]      rev_rdata;

    // Stage-one results.
    logic [7:0] s1_bytes [3];
    logic [1:0] s1_cnt;
    logic [15:0] uni;

    // Initialisation state machine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        clearing   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                clearing   = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                clearing = 1'b0;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Handshake.
    assign s1_adv     = r_s1_valid && ((r_ob_cnt == 2'd0) || ((r_ob_cnt == 2'd1) && i_out_ready));
    assign o_in_ready = !clearing && (!r_s1_valid || s1_adv);
    assign accept     = i_in_valid && o_in_ready;

    assign in_b       = i_in_item.in_byte;
    assign pair       = {r_first, in_b};
    assign euc_off    = pair - EUC_BASE;
    assign code_point = {r_first[3:0], r_second[5:0], in_b[5:0]};

    // Decode a data item against the held bytes.
    always_comb begin
        n_pending = r_pending;
        n_first   = r_first;
        n_second  = r_second;
        s0_load   = 1'b0;
        s0_job    = JOB_PASS;
        s0_hit    = 1'b0;
        fwd_re    = 1'b0;
        rev_re    = 1'b0;
        if (accept && (i_in_item.kind == KIND_DATA)) begin
            if (!r_direction) begin
                if (r_pending == PEND_EMPTY) begin
                    if (in_b[7]) begin
                        n_first   = in_b;
                        n_pending = PEND_ONE;
                    end else begin
                        s0_load = 1'b1;
                    end
                end else begin
                    n_pending = PEND_EMPTY;
                    if (pair >= EUC_BASE) begin
                        s0_load = 1'b1;
                        s0_job  = JOB_EUC;
                        s0_hit  = {1'b0, euc_off} < FWD_LIMIT;
                        fwd_re  = 1'b1;
                    end
                end
            end else begin
                case (r_pending)
                    PEND_EMPTY: begin
                        if ((in_b & UTF8_LEAD3) == UTF8_LEAD3) begin
                            n_first   = in_b;
                            n_pending = PEND_ONE;
                        end else begin
                            s0_load = 1'b1;
                        end
                    end
                    PEND_ONE: begin
                        n_second  = in_b;
                        n_pending = PEND_TWO;
                    end
                    default: begin
                        n_pending = PEND_EMPTY;
                        s0_load   = 1'b1;
                        s0_job    = JOB_UTF;
                        s0_hit    = {1'b0, code_point} < REV_LIMIT;
                        rev_re    = 1'b1;
                    end
                endcase
            end
        end
        if (i_cfg_we) begin
            n_pending = PEND_EMPTY;
        end
    end

    // Stream state and direction register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_pending   <= PEND_EMPTY;
            r_first     <= '0;
            r_second    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_direction <= i_cfg_data;
            end
            r_pending <= n_pending;
            r_first   <= n_first;
            r_second  <= n_second;
        end
    end

    // Table writes: the clearing sweep, then table-load items.
    always_comb begin
        if (clearing) begin
            fwd_we    = ((IDX_W + 1)'(r_clr_addr)) < FWD_LIMIT;
            fwd_waddr = r_clr_addr[FAW-1:0];
            fwd_wdata = '0;
            rev_we    = 1'b1;
            rev_waddr = r_clr_addr;
            rev_wdata = '0;
        end else begin
            fwd_we    = accept && (i_in_item.kind == KIND_FWD_LOAD)
                        && ({1'b0, i_in_item.table_index} < FWD_LIMIT);
            fwd_waddr = i_in_item.table_index[FAW-1:0];
            fwd_wdata = i_in_item.table_value;
            rev_we    = accept && (i_in_item.kind == KIND_REV_LOAD)
                        && ({1'b0, i_in_item.table_index} < REV_LIMIT);
            rev_waddr = i_in_item.table_index[RAW-1:0];
            rev_wdata = i_in_item.table_value;
        end
    end

    cp949u8_ram #(
        .WIDTH(16),
        .DEPTH(FORWARD_DEPTH)
    ) u_fwd_ram (
        .i_clk  (i_clk),
        .i_we   (fwd_we),
        .i_waddr(fwd_waddr),
        .i_wdata(fwd_wdata),
        .i_re   (fwd_re),
        .i_raddr(euc_off[FAW-1:0]),
        .o_rdata(fwd_rdata)
    );

    cp949u8_ram #(
        .WIDTH(16),
        .DEPTH(REVERSE_DEPTH)
    ) u_rev_ram (
        .i_clk  (i_clk),
        .i_we   (rev_we),
        .i_waddr(rev_waddr),
        .i_wdata(rev_wdata),
        .i_re   (rev_re),
        .i_raddr(code_point[RAW-1:0]),
        .o_rdata(rev_rdata)
    );

    // Lookup stage register; it waits there while the read data is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || s1_adv) begin
            r_s1_valid <= s0_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_load) begin
            r_s1_job    <= s0_job;
            r_s1_byte   <= in_b;
            r_s1_first  <= r_first;
            r_s1_second <= r_second;
            r_s1_hit    <= s0_hit;
        end
    end

    // Form the result bytes from the table data.
    always_comb begin
        uni         = r_s1_hit ? fwd_rdata : 16'h0000;
        s1_bytes[0] = r_s1_byte;
        s1_bytes[1] = 8'h00;
        s1_bytes[2] = 8'h00;
        s1_cnt      = 2'd1;
        case (r_s1_job)
            JOB_EUC: begin
                s1_bytes[0] = UTF8_LEAD3 | {4'h0, uni[15:12]};
                s1_bytes[1] = UTF8_CONT | {2'b00, uni[11:6]};
                s1_bytes[2] = UTF8_CONT | {2'b00, uni[5:0]};
                s1_cnt      = 2'd3;
            end
            JOB_UTF: begin
                if (r_s1_hit && (rev_rdata != 16'h0000)) begin
                    s1_bytes[0] = rev_rdata[15:8];
                    s1_bytes[1] = rev_rdata[7:0];
                    s1_cnt      = 2'd2;
                end else begin
                    // A miss copies the original bytes up to the first zero byte.
                    s1_bytes[0] = r_s1_first;
                    s1_bytes[1] = r_s1_second;
                    s1_bytes[2] = r_s1_byte;
                    if (r_s1_second == 8'h00) begin
                        s1_cnt = 2'd1;
                    end else if (r_s1_byte == 8'h00) begin
                        s1_cnt = 2'd2;
                    end else begin
                        s1_cnt = 2'd3;
                    end
                end
            end
            default: begin
                s1_cnt = 2'd1;
            end
        endcase
    end

    // Output buffer: loaded from the lookup stage, drained one byte per output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_cnt <= 2'd0;
        end else if (s1_adv) begin
            r_ob_cnt <= s1_cnt;
        end else if (o_out_valid && i_out_ready) begin
            r_ob_cnt <= r_ob_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_ob_byte <= s1_bytes;
        end else if (o_out_valid && i_out_ready) begin
            r_ob_byte[0] <= r_ob_byte[1];
            r_ob_byte[1] <= r_ob_byte[2];
        end
    end

    assign o_out_valid            = r_ob_cnt != 2'd0;
    assign o_out_item.out_byte    = r_ob_byte[0];
    assign o_out_item.last_of_run = r_ob_cnt == 2'd1;

endmodule

@@ rtl/cp949u8_checker.sv @@
// Port-level checker for the transcoder top level, bound to it below.
// Depends on cp949u8_pkg and the assertion macro header.
`include "cp949_utf8_transcoder_top_macros.svh"

module cp949u8_checker
    import cp949u8_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item,
    input logic      i_cfg_we
);

    // Handshake terms used by the properties.
    logic out_stall;
    logic run_more;
    logic in_take;

    assign out_stall = o_out_valid && !i_out_ready;
    assign run_more  = o_out_valid && i_out_ready && !o_out_item.last_of_run;
    assign in_take   = i_in_valid && o_in_ready;

    // A stalled result item keeps its payload.
    `CP949_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_item))

    // The bytes of one run follow each other without a gap.
    `CP949_ASSERT_NEXT(a_run_no_gap, i_clk, i_rst_n, run_more, o_out_valid)

    // After a reset cycle nothing is shown and no item is taken.
    `CP949_ASSERT_NEXT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !o_out_valid && !o_in_ready)

    // A configuration write never coincides with a completed input handshake.
    `CP949_ASSERT_SAME(a_cfg_idle, i_clk, i_rst_n, i_cfg_we, !in_take)

endmodule

bind cp949_utf8_transcoder_top cp949u8_checker u_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for the CP949 / UTF-8 transcoder top level.
// Depends on cp949u8_pkg and cp949_utf8_transcoder_top; output items are predicted
// from a local copy of both mapping tables and compared in order of arrival.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cp949u8_pkg::*;

    localparam int FWD_DEPTH     = 32768;
    localparam int REV_DEPTH     = 65536;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    // Item kind that the block ignores.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Block ports.
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_data  = 1'b0;

    // Stimulus and expected output bytes.
    t_in_item  pending_items[$];
    t_out_item expected_bytes[$];
    logic [15:0] fwd_codes[$];
    logic [15:0] rev_points[$];

    // Predicted state of the transcoder.
    bit [15:0]  euc_to_uni [FWD_DEPTH];
    bit [15:0]  uni_to_euc [REV_DEPTH];
    bit         dir_utf_to_euc = 1'b0;
    logic [1:0] held_count     = PEND_EMPTY;
    logic [7:0] held_lead      = 8'h00;
    logic [7:0] held_mid       = 8'h00;

    // Handshake and pacing control.
    logic in_taken      = 1'b0;
    bit   no_idle       = 1'b0;
    int   stall_asked   = 0;
    int   stall_seen    = 0;
    int   hold_left     = 0;
    int   mismatch_count = 0;
    int   cycle_count   = 0;

    always #5 i_clk = ~i_clk;

    cp949_utf8_transcoder_top #(
        .FORWARD_DEPTH (FWD_DEPTH),
        .REVERSE_DEPTH (REV_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic t_out_item as_result(logic [7:0] b);
        t_out_item r;
        r.out_byte    = b;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // Works out the output bytes of one accepted item and queues them.
    function automatic void transcode_item(t_in_item it);
        t_out_item   burst[$];
        logic [15:0] pair;
        logic [15:0] uni;
        logic [15:0] cp;
        logic [15:0] euc;
        case (it.kind)
            KIND_FWD_LOAD: begin
                // Indexes beyond the forward table are dropped.
                if (it.table_index < FWD_DEPTH) begin
                    euc_to_uni[it.table_index[14:0]] = it.table_value;
                end
            end
            KIND_REV_LOAD: begin
                uni_to_euc[it.table_index] = it.table_value;
            end
            KIND_DATA: begin
                if (!dir_utf_to_euc) begin
                    // EUC-KR to UTF-8: a high byte waits for its trail byte.
                    if (held_count == PEND_EMPTY) begin
                        if (it.in_byte[7]) begin
                            held_lead  = it.in_byte;
                            held_count = PEND_ONE;
                        end else begin
                            burst.push_back(as_result(it.in_byte));
                        end
                    end else begin
                        held_count = PEND_EMPTY;
                        pair = {held_lead, it.in_byte};
                        // Pairs below the table base produce nothing.
                        if (pair >= EUC_BASE) begin
                            uni = euc_to_uni[15'(pair - EUC_BASE)];
                            burst.push_back(as_result(UTF8_LEAD3 | {4'h0, uni[15:12]}));
                            burst.push_back(as_result(UTF8_CONT | {2'b00, uni[11:6]}));
                            burst.push_back(as_result(UTF8_CONT | {2'b00, uni[5:0]}));
                        end
                    end
                end else begin
                    // UTF-8 to EUC-KR: only 111xxxxx opens a three-byte sequence.
                    case (held_count)
                        PEND_EMPTY: begin
                            if ((it.in_byte & UTF8_LEAD3) == UTF8_LEAD3) begin
                                held_lead  = it.in_byte;
                                held_count = PEND_ONE;
                            end else begin
                                burst.push_back(as_result(it.in_byte));
                            end
                        end
                        PEND_ONE: begin
                            held_mid   = it.in_byte;
                            held_count = PEND_TWO;
                        end
                        default: begin
                            held_count = PEND_EMPTY;
                            cp  = {held_lead[3:0], held_mid[5:0], it.in_byte[5:0]};
                            euc = uni_to_euc[cp];
                            if (euc != 16'h0000) begin
                                burst.push_back(as_result(euc[15:8]));
                                burst.push_back(as_result(euc[7:0]));
                            end else begin
                                // A miss copies the raw bytes up to the first zero byte.
                                burst.push_back(as_result(held_lead));
                                if (held_mid != 8'h00) begin
                                    burst.push_back(as_result(held_mid));
                                    if (it.in_byte != 8'h00) begin
                                        burst.push_back(as_result(it.in_byte));
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
        if (burst.size() != 0) begin
            burst[burst.size() - 1].last_of_run = 1'b1;
        end
        foreach (burst[k]) begin
            expected_bytes.push_back(burst[k]);
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic push_byte(logic [7:0] b);
        t_in_item it;
        it.kind        = KIND_DATA;
        it.in_byte     = b;
        it.table_index = 16'($urandom);
        it.table_value = 16'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic push_load(logic [1:0] kind, logic [15:0] index, logic [15:0] value);
        t_in_item it;
        it.kind        = kind;
        it.in_byte     = 8'($urandom);
        it.table_index = index;
        it.table_value = value;
        pending_items.push_back(it);
    endtask

    // Queues random text for one direction: mostly well-formed sequences, some
    // table loads, and a little noise and truncated sequences.
    task automatic queue_random_text(int n_items, bit utf_mode);
        int          start;
        int          r;
        logic [15:0] code;
        logic [7:0]  lead;
        logic [7:0]  mid;
        logic [7:0]  tail;
        start = pending_items.size();
        while (pending_items.size() - start < n_items) begin
            r = $urandom_range(0, 99);
            if (!utf_mode) begin
                if (r < 25) begin
                    push_byte(8'($urandom_range(0, 127)));
                end else if (r < 70) begin
                    if (fwd_codes.size() != 0 && $urandom_range(0, 1) == 1) begin
                        code = fwd_codes[$urandom_range(0, fwd_codes.size() - 1)];
                    end else begin
                        code = {8'($urandom_range(128, 255)), 8'($urandom)};
                    end
                    push_byte(code[15:8]);
                    push_byte(code[7:0]);
                end else if (r < 85) begin
                    code = 16'($urandom_range(EUC_BASE, 16'hffff));
                    fwd_codes.push_back(code);
                    push_load(KIND_FWD_LOAD, code - EUC_BASE, 16'($urandom));
                end else if (r < 90) begin
                    push_load(KIND_FWD_LOAD, 16'($urandom), 16'($urandom));
                end else if (r < 95) begin
                    push_load(KIND_REV_LOAD, 16'($urandom), 16'($urandom));
                end else if (r < 97) begin
                    push_load(KIND_UNUSED, 16'($urandom), 16'($urandom));
                end else begin
                    // A lone lead byte pairs with whatever follows it.
                    push_byte(8'($urandom_range(128, 255)));
                end
            end else begin
                if (r < 20) begin
                    push_byte(8'($urandom_range(0, 8'hdf)));
                end else if (r < 70) begin
                    if (rev_points.size() != 0 && $urandom_range(0, 1) == 1) begin
                        code = rev_points[$urandom_range(0, rev_points.size() - 1)];
                    end else begin
                        code = 16'($urandom);
                    end
                    // Bits that the block ignores are filled at random.
                    lead = {3'b111, 1'($urandom), code[15:12]};
                    mid  = {2'($urandom), code[11:6]};
                    tail = {2'($urandom), code[5:0]};
                    if ($urandom_range(0, 9) == 0) begin
                        mid = 8'h00;
                    end else if ($urandom_range(0, 9) == 0) begin
                        tail = 8'h00;
                    end
                    push_byte(lead);
                    push_byte(mid);
                    push_byte(tail);
                end else if (r < 85) begin
                    code = 16'($urandom);
                    rev_points.push_back(code);
                    push_load(KIND_REV_LOAD, code,
                              ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom));
                end else if (r < 92) begin
                    push_load(KIND_FWD_LOAD, 16'($urandom), 16'($urandom));
                end else if (r < 96) begin
                    push_load(KIND_UNUSED, 16'($urandom), 16'($urandom));
                end else begin
                    // Truncated sequence; later bytes complete it.
                    push_byte({3'b111, 5'($urandom)});
                end
            end
        end
    endtask

    // Waits until every queued item is taken and every expected byte has come.
    task automatic wait_for_drain();
        do begin
            @(posedge i_clk);
        end while (pending_items.size() != 0 || i_in_valid || expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the direction register; any partly received sequence is dropped.
    task automatic set_direction(bit utf_to_euc);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= utf_to_euc;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        dir_utf_to_euc = utf_to_euc;
        held_count     = PEND_EMPTY;
    endtask

    // Input driver: presents the next pending item once the current one is taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_items.size() != 0 && (no_idle || $urandom_range(0, 99) >= 9)) begin
                i_in_item  <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output receiver: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (stall_seen != stall_asked) begin
            stall_seen = stall_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= 9);
        end
    end

    // Monitor: predicts on each accepted input item and checks each output item.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                transcode_item(i_in_item);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", o_out_item.out_byte));
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_item.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  o_out_item.out_byte, want.out_byte));
                    end
                    if (o_out_item.last_of_run !== want.last_of_run) begin
                        report_mismatch($sformatf("last_of_run %b, expected %b",
                                                  o_out_item.last_of_run, want.last_of_run));
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // EUC-KR to UTF-8 after reset: table extremes, ASCII, short pairs, misses.
        push_load(KIND_FWD_LOAD, 16'h0000, 16'hac00);
        push_load(KIND_FWD_LOAD, 16'h7ebe, 16'hffff);
        push_load(KIND_FWD_LOAD, 16'h8000, 16'hbeef);
        push_load(KIND_UNUSED, 16'hffff, 16'hffff);
        push_byte(8'h00);
        push_byte(8'h7f);
        push_byte(8'h81);
        push_byte(8'h41);
        push_byte(8'hff);
        push_byte(8'hff);
        push_byte(8'h81);
        push_byte(8'h40);
        push_byte(8'hb0);
        push_byte(8'ha1);
        // A table load between lead and trail leaves the lead byte held.
        push_byte(8'hc7);
        push_load(KIND_FWD_LOAD, 16'h4690, 16'hd55c);
        push_byte(8'hd1);
        wait_for_drain();

        // A lead byte left waiting is discarded by the direction write.
        push_byte(8'hb0);
        wait_for_drain();
        set_direction(1'b1);

        // UTF-8 to EUC-KR: hits, stray high byte, misses cut at a zero byte.
        push_load(KIND_REV_LOAD, 16'hd55c, 16'hc7d1);
        push_load(KIND_REV_LOAD, 16'hffff, 16'hffff);
        push_byte(8'h80);
        push_byte(8'hed);
        push_byte(8'h95);
        push_byte(8'h9c);
        push_byte(8'hef);
        push_byte(8'hbf);
        push_byte(8'hbf);
        push_byte(8'he1);
        push_byte(8'h00);
        push_byte(8'h41);
        push_byte(8'he2);
        push_byte(8'h41);
        push_byte(8'h00);
        push_byte(8'he3);
        push_byte(8'h85);
        push_byte(8'h86);
        wait_for_drain();

        // Random phases in both directions.
        queue_random_text(20, 1'b1);
        wait_for_drain();
        set_direction(1'b0);

        // Back-to-back traffic while the receiver holds off, so the block fills.
        no_idle = 1'b1;
        stall_asked++;
        queue_random_text(20, 1'b0);
        wait_for_drain();
        no_idle = 1'b0;
        set_direction(1'b1);

        queue_random_text(20, 1'b1);
        wait_for_drain();
        set_direction(1'b0);

        queue_random_text(20, 1'b0);
        wait_for_drain();

        repeat (20) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            report_mismatch($sformatf("%0d expected bytes never arrived",
                                      expected_bytes.size()));
        end
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
